[sv/bdte_pkg.sv]
// Shared constants, types and state encoding for the block delta trace encoder.
package bdte_pkg;

    localparam int MaxFrameWells = 4096;
    localparam int FrameAw       = $clog2(MaxFrameWells);
    localparam int MaxBlockWells = 16;
    localparam int BlkAw         = $clog2(MaxBlockWells);
    localparam int BlkCap        = (MaxBlockWells / 4) * 4;

    localparam logic signed [6:0] OffMax = 7'sd62;
    localparam logic signed [6:0] OffMin = -7'sd62;
    localparam logic [17:0]       Lim0   = 18'd7;
    localparam logic [17:0]       Lim1   = 18'd31;
    localparam logic [17:0]       Lim2   = 18'd127;

    localparam logic CFG_WPF = 1'b0;
    localparam logic CFG_WPB = 1'b1;

    typedef enum logic [1:0] {
        CODE_NIB,
        CODE_SIX,
        CODE_BYTE,
        CODE_RAW
    } t_code;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_RAW0,
        S_RAW1,
        S_OFFS,
        S_SCAN,
        S_HDR,
        S_BODY
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd;
        logic update;
        logic off_init;
        logic scan;
        logic emit_raw_lo;
        logic emit_raw_hi;
        logic emit_hdr;
        logic emit_body;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic close;
        logic scan_done;
        logic out_free;
        logic body_last;
    } t_sts;

endpackage

[sv/block_delta_trace_encoder.sv]
// Top level of the block delta trace encoder.
// One sample item at a time. A first-frame item passes the read, update and raw-byte states
// and yields its two raw bytes; a delta-frame item that does not close a block passes read
// and update only and yields nothing; an item that closes a block goes on to the offset state,
// a 16-entry max-magnitude scan, a header byte and 2 to 32 payload bytes, the output register
// moving one byte per cycle when the sink keeps ready high. The next item is taken as soon as
// the last byte sits in the output register. The frame history is a 4096 x 16 memory with one
// read and one write per item; entries never written since reset read as undefined.
module block_delta_trace_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [12:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_sample,
    input  logic                i_start_of_chunk,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_run
);

    bdte_pkg::t_cmd cmd;
    bdte_pkg::t_sts sts;

    bdte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bdte_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_sample         (i_sample),
        .i_start_of_chunk (i_start_of_chunk),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

[sv/bdte_ctrl.sv]
// Sequencing state machine for the block delta trace encoder.
module bdte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bdte_pkg::t_sts  i_sts,
    output bdte_pkg::t_cmd  o_cmd
);

    bdte_pkg::t_state r_state;
    bdte_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdte_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bdte_pkg::S_READ;
            end
            bdte_pkg::S_READ: begin
                n_state = bdte_pkg::S_UPDATE;
            end
            bdte_pkg::S_UPDATE: begin
                if (i_sts.first) n_state = bdte_pkg::S_RAW0;
                else if (i_sts.close) n_state = bdte_pkg::S_OFFS;
                else n_state = bdte_pkg::S_IDLE;
            end
            bdte_pkg::S_RAW0: begin
                if (i_sts.out_free) n_state = bdte_pkg::S_RAW1;
            end
            bdte_pkg::S_RAW1: begin
                if (i_sts.out_free) n_state = bdte_pkg::S_IDLE;
            end
            bdte_pkg::S_OFFS: begin
                n_state = bdte_pkg::S_SCAN;
            end
            bdte_pkg::S_SCAN: begin
                if (i_sts.scan_done) n_state = bdte_pkg::S_HDR;
            end
            bdte_pkg::S_HDR: begin
                if (i_sts.out_free) n_state = bdte_pkg::S_BODY;
            end
            bdte_pkg::S_BODY: begin
                if (i_sts.out_free && i_sts.body_last) n_state = bdte_pkg::S_IDLE;
            end
            default: n_state = bdte_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bdte_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bdte_pkg::S_READ:   o_cmd.rd = 1'b1;
            bdte_pkg::S_UPDATE: o_cmd.update = 1'b1;
            bdte_pkg::S_RAW0:   o_cmd.emit_raw_lo = i_sts.out_free;
            bdte_pkg::S_RAW1:   o_cmd.emit_raw_hi = i_sts.out_free;
            bdte_pkg::S_OFFS:   o_cmd.off_init = 1'b1;
            bdte_pkg::S_SCAN:   o_cmd.scan = 1'b1;
            bdte_pkg::S_HDR:    o_cmd.emit_hdr = i_sts.out_free;
            bdte_pkg::S_BODY:   o_cmd.emit_body = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[sv/bdte_dp.sv]
// Datapath: frame history memory, block registers, offset, width scan and byte packing.
module bdte_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [12:0]          i_cfg_wdata,
    input  logic signed [15:0]   i_sample,
    input  logic                 i_start_of_chunk,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_of_run,
    input  bdte_pkg::t_cmd       i_cmd,
    output bdte_pkg::t_sts       o_sts
);

    localparam int Aw = bdte_pkg::FrameAw;
    localparam int Bw = bdte_pkg::BlkAw;
    localparam int Nb = bdte_pkg::MaxBlockWells;

    logic [12:0]               r_wpf;
    logic [4:0]                r_wpb;
    logic [Aw-1:0]             r_pos;
    logic [4:0]                r_fill;
    logic                      r_first;
    logic signed [15:0]        r_smp;
    logic signed [15:0]        r_prev;
    logic [15:0]               r_mem [bdte_pkg::MaxFrameWells];
    logic signed [16:0]        r_dlt [Nb];
    logic [15:0]               r_raw [Nb];
    logic [4:0]                r_n;
    logic signed [6:0]         r_off;
    logic [Bw-1:0]             r_scnt;
    logic [17:0]               r_max;
    bdte_pkg::t_code           r_code;
    logic [4:0]                r_ei;
    logic [1:0]                r_ph;
    logic                      r_ovld;
    logic [7:0]                r_obyte;
    logic                      r_olast;

    logic [12:0]               wpf_use;
    logic [4:0]                bs_raw;
    logic [4:0]                bs;
    logic                      frame_end;
    logic [4:0]                fill_eff;
    logic [4:0]                fill_inc;
    logic                      close;
    logic signed [18:0]        sum4;
    logic signed [18:0]        quo;
    logic signed [6:0]         off_c;
    logic signed [17:0]        sv0;
    logic [17:0]               sabs;
    logic                      scan_ok;
    bdte_pkg::t_code           code_c;
    logic signed [17:0]        v [4];
    logic [15:0]               rw0;
    logic [3:0]                nb0;
    logic [3:0]                nb1;
    logic [5:0]                sx [4];
    logic [7:0]                by0;
    logic [7:0]                body_byte;
    logic [2:0]                body_k;
    logic [5:0]                ei_next;
    logic                      body_last;
    logic                      out_free;
    logic [6:0]                off_bias;

    always_comb begin
        if (r_wpf == 13'd0) wpf_use = 13'd1;
        else if (r_wpf > 13'(bdte_pkg::MaxFrameWells)) wpf_use = 13'(bdte_pkg::MaxFrameWells);
        else wpf_use = r_wpf;
        bs_raw = {r_wpb[4:2], 2'b00};
        if (bs_raw < 5'd4) bs = 5'd4;
        else if (bs_raw > 5'(bdte_pkg::BlkCap)) bs = 5'(bdte_pkg::BlkCap);
        else bs = bs_raw;
        frame_end = ({1'b0, r_pos} + 13'd1) >= wpf_use;
        fill_eff  = (r_fill >= bs) ? 5'd0 : r_fill;
        fill_inc  = fill_eff + 5'd1;
        close     = (fill_inc >= bs) || frame_end;
    end

    always_comb begin
        sum4 = '0;
        for (int j = 0; j < 4; j++) begin
            if (5'(j) < r_n) sum4 = sum4 + 19'(r_dlt[j]);
        end
        quo = sum4 >>> 2;
        if (quo > 19'(bdte_pkg::OffMax)) off_c = bdte_pkg::OffMax;
        else if (quo < 19'(bdte_pkg::OffMin)) off_c = bdte_pkg::OffMin;
        else off_c = quo[6:0];
        off_c[0] = 1'b0;
    end

    always_comb begin
        sv0     = 18'(r_dlt[0]) - 18'(r_off);
        sabs    = sv0[17] ? 18'(-sv0) : 18'(sv0);
        scan_ok = {1'b0, r_scnt} < r_n;
        if (r_max <= bdte_pkg::Lim0) code_c = bdte_pkg::CODE_NIB;
        else if (r_max <= bdte_pkg::Lim1) code_c = bdte_pkg::CODE_SIX;
        else if (r_max <= bdte_pkg::Lim2) code_c = bdte_pkg::CODE_BYTE;
        else code_c = bdte_pkg::CODE_RAW;
        off_bias = 7'(r_off + bdte_pkg::OffMax);
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (({1'b0, r_ei} + 6'(j)) < {1'b0, r_n}) v[j] = 18'(r_dlt[j]) - 18'(r_off);
            else v[j] = '0;
            sx[j] = 6'(v[j] + 18'sd31);
        end
        rw0 = (({1'b0, r_ei}) < {1'b0, r_n}) ? r_raw[0] : 16'd0;
        nb0 = 4'(v[0] + 18'sd7);
        nb1 = 4'(v[1] + 18'sd7);
        by0 = 8'(v[0] + 18'sd127);
        body_byte = '0;
        body_k    = 3'd0;
        unique case (r_code)
            bdte_pkg::CODE_NIB: begin
                body_byte = {nb0, nb1};
                body_k    = 3'd2;
            end
            bdte_pkg::CODE_SIX: begin
                unique case (r_ph)
                    2'd0: body_byte = {sx[0], sx[1][5:4]};
                    2'd1: body_byte = {sx[1][3:0], sx[2][5:2]};
                    default: begin
                        body_byte = {sx[2][1:0], sx[3]};
                        body_k    = 3'd4;
                    end
                endcase
            end
            bdte_pkg::CODE_BYTE: begin
                body_byte = by0;
                body_k    = 3'd1;
            end
            bdte_pkg::CODE_RAW: begin
                if (r_ph == 2'd0) begin
                    body_byte = rw0[7:0];
                end else begin
                    body_byte = rw0[15:8];
                    body_k    = 3'd1;
                end
            end
            default: body_byte = '0;
        endcase
        ei_next   = {1'b0, r_ei} + 6'(body_k);
        body_last = (body_k != 3'd0) && (ei_next >= {1'b0, bs});
    end

    assign out_free = !r_ovld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_prev <= r_mem[r_pos];
        if (i_cmd.update) r_mem[r_pos] <= r_smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpf   <= 13'(bdte_pkg::MaxFrameWells);
            r_wpb   <= 5'd8;
            r_pos   <= '0;
            r_fill  <= '0;
            r_first <= 1'b1;
            r_ovld  <= 1'b0;
            r_n     <= '0;
            for (int j = 0; j < Nb; j++) begin
                r_dlt[j] <= '0;
                r_raw[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bdte_pkg::CFG_WPF) begin
                    r_wpf <= i_cfg_wdata;
                end else begin
                    r_wpb  <= i_cfg_wdata[4:0];
                    r_fill <= '0;
                end
            end
            if (i_cmd.capture) begin
                r_smp <= i_sample;
                if (i_start_of_chunk) begin
                    r_pos   <= '0;
                    r_fill  <= '0;
                    r_first <= 1'b1;
                end
            end
            if (i_cmd.update) begin
                if (!r_first) begin
                    r_dlt[fill_eff[Bw-1:0]] <= 17'(r_smp) - 17'(r_prev);
                    r_raw[fill_eff[Bw-1:0]] <= r_smp;
                    r_n    <= fill_inc;
                    r_fill <= close ? 5'd0 : fill_inc;
                end
                if (frame_end) begin
                    r_pos   <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.off_init) begin
                r_off  <= off_c;
                r_scnt <= '0;
                r_max  <= '0;
            end
            if (i_cmd.scan) begin
                if (scan_ok && (sabs > r_max)) r_max <= sabs;
                r_scnt <= r_scnt + 1'b1;
                for (int j = 0; j < Nb; j++) begin
                    r_dlt[j] <= r_dlt[(j + 1) % Nb];
                    r_raw[j] <= r_raw[(j + 1) % Nb];
                end
            end
            if (i_cmd.emit_hdr) begin
                r_code <= code_c;
                r_ei   <= '0;
                r_ph   <= '0;
            end
            if (i_cmd.emit_body) begin
                r_ei <= ei_next[4:0];
                r_ph <= (body_k != 3'd0) ? 2'd0 : r_ph + 2'd1;
                for (int j = 0; j < Nb; j++) begin
                    if (j + int'(body_k) < Nb) begin
                        r_dlt[j] <= r_dlt[(j + int'(body_k)) % Nb];
                        r_raw[j] <= r_raw[(j + int'(body_k)) % Nb];
                    end else begin
                        r_dlt[j] <= '0;
                        r_raw[j] <= '0;
                    end
                end
            end
            if (i_cmd.emit_raw_lo || i_cmd.emit_raw_hi || i_cmd.emit_hdr
                || i_cmd.emit_body) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_raw_lo) begin
            r_obyte <= r_smp[7:0];
            r_olast <= 1'b0;
        end else if (i_cmd.emit_raw_hi) begin
            r_obyte <= r_smp[15:8];
            r_olast <= 1'b1;
        end else if (i_cmd.emit_hdr) begin
            r_obyte <= {code_c, off_bias[6:1]};
            r_olast <= 1'b0;
        end else if (i_cmd.emit_body) begin
            r_obyte <= body_byte;
            r_olast <= body_last;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_out_byte    = r_obyte;
    assign o_last_of_run = r_olast;

    always_comb begin
        o_sts.first     = r_first;
        o_sts.close     = close;
        o_sts.scan_done = (r_scnt == Bw'(Nb - 1));
        o_sts.out_free  = out_free;
        o_sts.body_last = body_last;
    end

endmodule

[sv/bdte_chk.sv]
// Port-level checker for the block delta trace encoder, bound to the top level.
module bdte_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_out_byte) && $stable(o_last_of_run)))
        else $error("output item changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

endmodule

bind block_delta_trace_encoder bdte_chk u_bdte_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);

[verif/block_delta_trace_encoder_tb.sv]
// Self-checking testbench for the block delta trace encoder: random handshakes, byte predictor.
module block_delta_trace_encoder_tb;

    class delta_stream_model;
        int unsigned frame_reg;
        int unsigned block_reg;
        logic signed [15:0] history [bdte_pkg::MaxFrameWells];
        bit seen [bdte_pkg::MaxFrameWells];
        int blk_val [bdte_pkg::MaxBlockWells];
        int blk_delta [bdte_pkg::MaxBlockWells];
        int unsigned pos;
        int unsigned fill;
        bit first_frame;
        bit [7:0] want_byte [$];
        bit want_last [$];
        int errors;

        function new();
            frame_reg = 4096;
            block_reg = 8;
            pos = 0;
            fill = 0;
            first_frame = 1;
            errors = 0;
            foreach (blk_val[i]) begin
                blk_val[i] = 0;
                blk_delta[i] = 0;
            end
        endfunction

        function int unsigned frame_len();
            int unsigned w;
            w = frame_reg;
            if (w < 1) w = 1;
            if (w > bdte_pkg::MaxFrameWells) w = bdte_pkg::MaxFrameWells;
            return w;
        endfunction

        function int unsigned block_len();
            int unsigned b;
            b = block_reg & ~32'd3;
            if (b < 4) b = 4;
            if (b > bdte_pkg::BlkCap) b = bdte_pkg::BlkCap;
            return b;
        endfunction

        function int unsigned cur_pos();
            return (pos >= bdte_pkg::MaxFrameWells) ? 0 : pos;
        endfunction

        function void write_reg(logic idx, int unsigned value);
            if (idx == bdte_pkg::CFG_WPF) begin
                frame_reg = value & 13'h1FFF;
            end else begin
                block_reg = value & 5'h1F;
                fill = 0;
            end
        endfunction

        function void push(int b);
            want_byte.push_back(b[7:0]);
            want_last.push_back(1'b0);
        endfunction

        function void code_block(int unsigned len, int unsigned n);
            int vals [bdte_pkg::MaxBlockWells];
            int raws [bdte_pkg::MaxBlockWells];
            int sum, off, maxabs, a;
            bdte_pkg::t_code code;
            sum = 0;
            maxabs = 0;
            for (int i = 0; i < 4 && i < n; i++) sum += blk_delta[i];
            off = (sum >= 0) ? sum / 4 : -((-sum + 3) / 4);
            if (off > 62) off = 62;
            if (off < -62) off = -62;
            if (off & 1) off -= 1;
            for (int i = 0; i < len; i++) begin
                if (i < n) begin
                    vals[i] = blk_delta[i] - off;
                    raws[i] = blk_val[i];
                    a = vals[i] < 0 ? -vals[i] : vals[i];
                    if (a > maxabs) maxabs = a;
                end else begin
                    vals[i] = 0;
                    raws[i] = 0;
                end
            end
            if (maxabs <= 7) code = bdte_pkg::CODE_NIB;
            else if (maxabs <= 31) code = bdte_pkg::CODE_SIX;
            else if (maxabs <= 127) code = bdte_pkg::CODE_BYTE;
            else code = bdte_pkg::CODE_RAW;
            push((int'(code) << 6) | ((off + 62) >> 1));
            case (code)
                bdte_pkg::CODE_NIB: begin
                    for (int i = 0; i + 1 < len; i += 2)
                        push((((vals[i] + 7) & 15) << 4) | ((vals[i + 1] + 7) & 15));
                end
                bdte_pkg::CODE_SIX: begin
                    for (int i = 0; i + 3 < len; i += 4) begin
                        int a0, a1, a2, a3;
                        a0 = (vals[i] + 31) & 63;
                        a1 = (vals[i + 1] + 31) & 63;
                        a2 = (vals[i + 2] + 31) & 63;
                        a3 = (vals[i + 3] + 31) & 63;
                        push((a0 << 2) | (a1 >> 4));
                        push((a1 << 4) | ((a2 >> 2) & 15));
                        push((a2 << 6) | a3);
                    end
                end
                bdte_pkg::CODE_BYTE: begin
                    for (int i = 0; i < len; i++) push(vals[i] + 127);
                end
                default: begin
                    for (int i = 0; i < len; i++) begin
                        push(raws[i] & 255);
                        push((raws[i] >> 8) & 255);
                    end
                end
            endcase
        endfunction

        function void take_sample(logic signed [15:0] s, bit soc);
            int unsigned wpf, bs, p, f, base;
            bit frame_end;
            wpf = frame_len();
            bs = block_len();
            base = want_byte.size();
            if (soc) begin
                pos = 0;
                fill = 0;
                first_frame = 1;
            end
            p = cur_pos();
            frame_end = (p + 1 >= wpf);
            if (first_frame) begin
                push(int'(s[7:0]));
                push(int'(s[15:8]));
            end else begin
                f = (fill >= bs) ? 0 : fill;
                blk_delta[f] = int'(s) - int'(history[p]);
                blk_val[f] = int'(s);
                f++;
                if (f >= bs || frame_end) begin
                    code_block(bs, f);
                    f = 0;
                end
                fill = f;
            end
            history[p] = s;
            seen[p] = 1;
            if (frame_end) begin
                pos = 0;
                first_frame = 0;
            end else begin
                pos = p + 1;
            end
            if (want_byte.size() > base) want_last[want_last.size() - 1] = 1'b1;
        endfunction

        function void match_byte(bit [7:0] b, bit l);
            bit [7:0] eb;
            bit el;
            if (want_byte.size() == 0) begin
                $display("%0t: unexpected byte %h last %b", $time, b, l);
                errors++;
                return;
            end
            eb = want_byte.pop_front();
            el = want_last.pop_front();
            if (eb != b) begin
                $display("%0t: out_byte expected %h actual %h", $time, eb, b);
                errors++;
            end
            if (el != l) begin
                $display("%0t: last_of_run expected %b actual %b", $time, el, l);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [12:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_sample;
    logic               i_start_of_chunk;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [7:0]         o_out_byte;
    logic               o_last_of_run;

    delta_stream_model stream = new();
    bit calm;
    int cycles;
    int sent;

    block_delta_trace_encoder i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("status: fail");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) stream.match_byte(o_out_byte, o_last_of_run);
    end

    task automatic settle();
        i_in_valid <= 0;
        wait (stream.want_byte.size() == 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value[12:0];
        stream.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [15:0] pick_sample(int cls, int bias);
        int prev, d;
        if (stream.first_frame || cls > 3) begin
            case ($urandom_range(5))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3: return 16'hFFFF;
                default: return 16'($urandom_range(16'hFFFF));
            endcase
        end
        prev = int'(stream.history[stream.cur_pos()]);
        case (cls)
            0: d = $urandom_range(14) - 7;
            1: d = $urandom_range(62) - 31;
            2: d = $urandom_range(254) - 127;
            default: d = $urandom_range(16'hFFFF);
        endcase
        return 16'(prev + bias + d);
    endfunction

    task automatic send(logic [15:0] s, bit soc);
        if (!soc && !stream.first_frame && !stream.seen[stream.cur_pos()]) soc = 1;
        while (!calm && $urandom_range(99) < 35) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_sample <= s;
        i_start_of_chunk <= soc;
        do @(posedge i_clk); while (!o_in_ready);
        stream.take_sample(s, soc);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(int cls, int bias, bit soc_ok);
        send(pick_sample(cls, bias), soc_ok && ($urandom_range(99) < 3));
    endtask

    initial begin
        int cls, bias, wpf, count;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = bdte_pkg::CFG_WPF;
        i_cfg_wdata = 0;
        i_in_valid = 0;
        i_sample = 0;
        i_start_of_chunk = 0;
        i_out_ready = 0;
        calm = 0;
        cycles = 0;
        sent = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        write_reg(bdte_pkg::CFG_WPF, 4);
        write_reg(bdte_pkg::CFG_WPB, 4);
        send(16'h8000, 1);
        send(16'h7FFF, 0);
        send(16'h0000, 0);
        send(16'hFFFF, 0);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) send(pick_sample(c, 0), 0);
        for (int i = 0; i < 4; i++) send(pick_sample(0, 300), 0);
        for (int i = 0; i < 4; i++) send(pick_sample(1, -300), 0);

        settle();
        write_reg(bdte_pkg::CFG_WPF, 8191);
        write_reg(bdte_pkg::CFG_WPB, 31);
        for (int i = 0; i < 6; i++) send(pick_sample(4, 0), i == 0);
        settle();
        write_reg(bdte_pkg::CFG_WPF, 0);
        write_reg(bdte_pkg::CFG_WPB, 0);
        for (int i = 0; i < 6; i++) send(pick_sample(i % 4, 0), i == 0);

        while (sent < 300) begin
            settle();
            calm = (sent > 150 && sent < 220);
            case ($urandom_range(8))
                0: wpf = 1;
                1: wpf = 2;
                2: wpf = 3;
                3: wpf = 5;
                4: wpf = 7;
                5: wpf = 10;
                6: wpf = 16;
                7: wpf = 23;
                default: wpf = 33;
            endcase
            if ($urandom_range(3) != 0) write_reg(bdte_pkg::CFG_WPF, wpf);
            if ($urandom_range(3) != 0) write_reg(bdte_pkg::CFG_WPB, $urandom_range(31));
            count = $urandom_range(3 * stream.frame_len() + 2, 1);
            if (count > 60) count = 60;
            for (int i = 0; i < count; i++) begin
                if (stream.fill == 0) begin
                    cls = $urandom_range(4);
                    bias = ($urandom_range(3) == 0) ? $urandom_range(600) - 300
                                                    : $urandom_range(20) - 10;
                end
                send_random(cls, bias, i > 0);
            end
        end
        calm = 0;
        settle();
        if (stream.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[files.f]
sv/bdte_pkg.sv
sv/bdte_ctrl.sv
sv/bdte_dp.sv
sv/block_delta_trace_encoder.sv
sv/bdte_chk.sv
verif/block_delta_trace_encoder_tb.sv
